// ===== design/prac_pkg.sv =====
package prac_pkg;

  // Default sizes
  localparam int COORD_WIDTH        = 16;
  localparam int ANGLE_WIDTH        = 16;
  localparam int TRIG_FRACTION_BITS = 16;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_Y = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_X = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ANGLE_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIVOT_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIVOT_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIVOT_Z = 3'd5;

  // pi/2 in Q30, split into 16-bit halves for the shared multiplier
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] HALF_PI_LO  = {16'd0, HALF_PI_Q30[15:0]};
  localparam logic [31:0] HALF_PI_HI  = {16'd0, HALF_PI_Q30[31:16]};

  // Sine generator sequencer
  typedef enum logic [3:0] {
    TS_IDLE,
    TS_START,
    TS_TH_LO,
    TS_TH_HI,
    TS_TH_SUM,
    TS_MUL1,
    TS_MUL2,
    TS_DIV_LOAD,
    TS_DIV,
    TS_ACC,
    TS_ROUND
  } trig_state_t;

  // Reciprocal of the Taylor term divisor d = (2k)(2k+1), k = kidx + 1:
  // floor(n / d) = (n * (2^32 + recip)) >> shift for every 32-bit n
  function automatic logic [31:0] term_recip(input logic [2:0] kidx);
    logic [31:0] m;
    case (kidx)
      3'd0:    m = 32'd1431655766;
      3'd1:    m = 32'd2576980378;
      3'd2:    m = 32'd2249744775;
      3'd3:    m = 32'd3340530120;
      3'd4:    m = 32'd702812831;
      3'd5:    m = 32'd2753184165;
      3'd6:    m = 32'd940802361;
      default: m = 32'd3789677026;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] term_shift(input logic [2:0] kidx);
    logic [5:0] s;
    case (kidx)
      3'd0:    s = 6'd35;
      3'd1:    s = 6'd37;
      3'd2:    s = 6'd38;
      3'd3:    s = 6'd39;
      3'd4:    s = 6'd39;
      3'd5:    s = 6'd40;
      3'd6:    s = 6'd40;
      default: s = 6'd41;
    endcase
    return s;
  endfunction

endpackage

// ===== design/prac_if.sv =====
interface prac_in_if #(
  parameter int COORD_WIDTH = prac_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface prac_out_if #(
  parameter int ROT_WIDTH = prac_pkg::COORD_WIDTH + 3
);
  logic                        valid;
  logic                        ready;
  logic signed [ROT_WIDTH-1:0] rotated_x;
  logic signed [ROT_WIDTH-1:0] rotated_y;
  logic signed [ROT_WIDTH-1:0] rotated_z;

  modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// ===== design/prac_trig.sv =====
module prac_trig #(
  parameter int ANGLE_WIDTH        = prac_pkg::ANGLE_WIDTH,
  parameter int TRIG_FRACTION_BITS = prac_pkg::TRIG_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [2:0]                          ang_we,
  input  logic [ANGLE_WIDTH-1:0]              ang_wdata,
  output logic                                busy,
  output logic signed [TRIG_FRACTION_BITS+1:0] cos_o [3],
  output logic signed [TRIG_FRACTION_BITS+1:0] sin_o [3]
);
  import prac_pkg::*;

  localparam int AW  = ANGLE_WIDTH;
  localparam int F   = TRIG_FRACTION_BITS;
  localparam int QW  = AW - 2;
  localparam int RSH = 30 - F;
  localparam logic [AW-2:0] QUARTER = {1'b1, {QW{1'b0}}};
  localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< 30;
  localparam logic [F:0] ONE_F = {1'b1, {F{1'b0}}};

  logic [AW-1:0]     angle_r [3];
  logic [2:0]        pend_r;
  logic [2:0]        pend_nxt;
  trig_state_t       state_r, state_nxt;
  logic [1:0]        axis_r;
  logic [1:0]        quad_r;
  logic [QW-1:0]     frac_r;
  logic [AW-2:0]     arg_r;
  logic              pass_r;
  logic [63:0]       prod_r;
  logic [63:0]       lo_r;
  logic [31:0]       x_r;
  logic [31:0]       t_r;
  logic [31:0]       dq_r;
  logic [2:0]        kidx_r;
  logic signed [33:0] s_r;
  logic [F:0]        sv_r;

  logic [1:0]        pick;
  logic [2:0]        pick_oh;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       theta_sum;
  logic [63:0]       theta_sh;
  logic [31:0]       theta;
  logic [64:0]       q_sum;
  logic [64:0]       q_shift;
  logic [31:0]       quot;
  logic [30:0]       s_clamp;
  logic [31:0]       s_rnd;
  logic [F:0]        round_val;
  logic signed [F+1:0] sp, cp;
  logic signed [F+1:0] sin_nxt, cos_nxt;

  // Pick the lowest pending axis
  always_comb begin
    if (pend_r[0]) begin
      pick = 2'd0;
    end else if (pend_r[1]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
    pick_oh = 3'b001 << pick;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TS_IDLE:     if (|pend_r) state_nxt = TS_START;
      TS_START: begin
        if (arg_r == '0 || arg_r == QUARTER) begin
          state_nxt = TS_ROUND;
        end else begin
          state_nxt = TS_TH_LO;
        end
      end
      TS_TH_LO:    state_nxt = TS_TH_HI;
      TS_TH_HI:    state_nxt = TS_TH_SUM;
      TS_TH_SUM:   state_nxt = TS_MUL1;
      TS_MUL1:     state_nxt = TS_MUL2;
      TS_MUL2:     state_nxt = TS_DIV_LOAD;
      TS_DIV_LOAD: state_nxt = TS_DIV;
      TS_DIV:      state_nxt = TS_ACC;
      TS_ACC:      state_nxt = (kidx_r == '1) ? TS_ROUND : TS_MUL1;
      TS_ROUND:    state_nxt = pass_r ? TS_IDLE : TS_START;
      default:     state_nxt = TS_IDLE;
    endcase
  end

  // Datapath controls: multiplier operands, reciprocal divide, rounding
  always_comb begin
    case (state_r)
      TS_TH_LO: begin
        mul_a = 32'(arg_r);
        mul_b = HALF_PI_LO;
      end
      TS_TH_HI: begin
        mul_a = 32'(arg_r);
        mul_b = HALF_PI_HI;
      end
      TS_MUL1: begin
        mul_a = t_r;
        mul_b = x_r;
      end
      TS_MUL2: begin
        mul_a = prod_r[61:30];
        mul_b = x_r;
      end
      TS_DIV: begin
        mul_a = dq_r;
        mul_b = term_recip(kidx_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p     = 64'(mul_a) * 64'(mul_b);
    theta_sum = (prod_r << 16) + lo_r;
    theta_sh  = theta_sum >> QW;
    theta     = theta_sh[31:0];

    // Quotient: add the implicit 2^32 part of the reciprocal, then shift
    q_sum     = {1'b0, prod_r} + {1'b0, dq_r, 32'd0};
    q_shift   = q_sum >> term_shift(kidx_r);
    quot      = q_shift[31:0];

    if (s_r < 0) begin
      s_clamp = '0;
    end else if (s_r > ONE_Q30) begin
      s_clamp = ONE_Q30[30:0];
    end else begin
      s_clamp = s_r[30:0];
    end
    s_rnd     = (32'(s_clamp) + (32'd1 << (RSH - 1))) >> RSH;
    round_val = s_rnd[F:0];

    sp = $signed({1'b0, sv_r});
    cp = $signed({1'b0, round_val});
    case (quad_r)
      2'd0: begin
        sin_nxt = sp;
        cos_nxt = cp;
      end
      2'd1: begin
        sin_nxt = cp;
        cos_nxt = -sp;
      end
      2'd2: begin
        sin_nxt = -sp;
        cos_nxt = -cp;
      end
      default: begin
        sin_nxt = -cp;
        cos_nxt = sp;
      end
    endcase

    pend_nxt = pend_r;
    if (state_r == TS_IDLE && |pend_r) begin
      pend_nxt = pend_r & ~pick_oh;
    end
    pend_nxt = pend_nxt | ang_we;
  end

  assign busy = (state_r != TS_IDLE) || (|pend_r);

  // Control state, angle registers and trig cache
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      pend_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        angle_r[i] <= '0;
        cos_o[i]   <= $signed({2'b01, {F{1'b0}}});
        sin_o[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      for (int i = 0; i < 3; i++) begin
        if (ang_we[i]) angle_r[i] <= ang_wdata;
      end
      if (state_r == TS_ROUND && pass_r) begin
        cos_o[axis_r] <= cos_nxt;
        sin_o[axis_r] <= sin_nxt;
      end
    end
  end

  // Series evaluation datapath
  always_ff @(posedge clk) begin
    case (state_r)
      TS_IDLE: begin
        axis_r <= pick;
        quad_r <= angle_r[pick][AW-1:AW-2];
        frac_r <= angle_r[pick][QW-1:0];
        arg_r  <= {1'b0, angle_r[pick][QW-1:0]};
        pass_r <= 1'b0;
      end
      TS_START: begin
        kidx_r <= '0;
        if (arg_r == '0) begin
          s_r <= '0;
        end else if (arg_r == QUARTER) begin
          s_r <= ONE_Q30;
        end
      end
      TS_TH_LO: prod_r <= mul_p;
      TS_TH_HI: begin
        lo_r   <= prod_r;
        prod_r <= mul_p;
      end
      TS_TH_SUM: begin
        x_r <= theta;
        t_r <= theta;
        s_r <= $signed({2'b00, theta});
      end
      TS_MUL1: prod_r <= mul_p;
      TS_MUL2: prod_r <= mul_p;
      TS_DIV_LOAD: dq_r <= prod_r[61:30];
      TS_DIV: prod_r <= mul_p;
      TS_ACC: begin
        // odd terms subtract, even terms add
        if (!kidx_r[0]) begin
          s_r <= s_r - $signed({2'b00, quot});
        end else begin
          s_r <= s_r + $signed({2'b00, quot});
        end
        t_r    <= quot;
        kidx_r <= kidx_r + 3'd1;
      end
      TS_ROUND: begin
        if (!pass_r) begin
          sv_r   <= round_val;
          pass_r <= 1'b1;
          arg_r  <= QUARTER - {1'b0, frac_r};
        end
      end
      default: ;
    endcase
  end

  a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == TS_ROUND |-> round_val <= ONE_F)
    else $error("sine magnitude above one");

  a_write_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|ang_we) |=> busy)
    else $error("angle write did not start regeneration");

endmodule

// ===== design/prac_rotate.sv =====
module prac_rotate #(
  parameter int VW = prac_pkg::COORD_WIDTH + 3,
  parameter int TW = prac_pkg::TRIG_FRACTION_BITS + 2,
  parameter int F  = prac_pkg::TRIG_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] a_i,
  input  logic signed [VW-1:0] b_i,
  input  logic signed [VW-1:0] p_i,
  input  logic signed [TW-1:0] cos_i,
  input  logic signed [TW-1:0] sin_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VW-1:0] a_o,
  output logic signed [VW-1:0] b_o,
  output logic signed [VW-1:0] p_o
);
  localparam int PW = VW + TW;
  localparam int SW = PW + 1;

  logic                 v1_r, v2_r, v3_r;
  logic                 rdy1, rdy2, rdy3;
  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [VW-1:0] p1_r, p2_r;
  logic signed [SW-1:0] sa_r, sb_r;
  logic signed [SW-1:0] sa_nxt, sb_nxt;
  logic signed [SW-1:0] bias_a, bias_b;
  logic signed [SW-1:0] ta, tb;
  logic signed [SW-1:0] tsa, tsb;

  // Each stage moves when the one after it is empty or moving
  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3_r;

  assign sa_nxt = SW'(ac_r) - SW'(bs_r);
  assign sb_nxt = SW'(as_r) + SW'(bc_r);

  // Truncate toward zero: bias negatives before the shift
  assign bias_a = sa_r[SW-1] ? $signed({{(SW-F){1'b0}}, {F{1'b1}}}) : '0;
  assign bias_b = sb_r[SW-1] ? $signed({{(SW-F){1'b0}}, {F{1'b1}}}) : '0;
  assign ta     = sa_r + bias_a;
  assign tb     = sb_r + bias_b;
  assign tsa    = ta >>> F;
  assign tsb    = tb >>> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Products, then sums, then truncation
  always_ff @(posedge clk) begin
    if (rdy1) begin
      ac_r <= PW'(a_i) * PW'(cos_i);
      bs_r <= PW'(b_i) * PW'(sin_i);
      as_r <= PW'(a_i) * PW'(sin_i);
      bc_r <= PW'(b_i) * PW'(cos_i);
      p1_r <= p_i;
    end
    if (rdy2) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      p2_r <= p1_r;
    end
    if (rdy3) begin
      a_o <= tsa[VW-1:0];
      b_o <= tsb[VW-1:0];
      p_o <= p2_r;
    end
  end

  a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && v3_r && !out_ready) |=> (v2_r && $stable(sa_r) && $stable(sb_r)))
    else $error("middle stage lost a word under stall");

endmodule

// ===== design/point_rotate_about_center_core.sv =====
// Channel   Dir  Fields                              Handshake
// in_point  in   point_x, point_y, point_z           valid/ready
// out_point out  rotated_x, rotated_y, rotated_z     valid/ready
// cfg_*     in   cfg_index, cfg_wdata                cfg_we, no wait
//
// One point per cycle while the output side is ready and the sine unit is idle;
// the path is pivot subtract, three rotations of three stages each, and pivot add
// into the output register. After an angle write the sine unit regenerates that
// axis with two Taylor series of x plus eight further terms, each term passing
// through MUL1, MUL2, DIV_LOAD, DIV and ACC; input is held off meanwhile. Reset:
// angles and pivots zero, cosines one, sines zero. Each stage advances whenever the one after it is empty or moving.
module point_rotate_about_center_core #(
  parameter int COORD_WIDTH        = prac_pkg::COORD_WIDTH,
  parameter int ANGLE_WIDTH        = prac_pkg::ANGLE_WIDTH,
  parameter int TRIG_FRACTION_BITS = prac_pkg::TRIG_FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  prac_in_if.sink                               in_point,
  prac_out_if.source                            out_point,
  input  logic                                  cfg_we,
  input  logic [prac_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [((ANGLE_WIDTH > COORD_WIDTH) ? ANGLE_WIDTH : COORD_WIDTH)-1:0] cfg_wdata
);
  import prac_pkg::*;

  localparam int VW = COORD_WIDTH + 3;
  localparam int TW = TRIG_FRACTION_BITS + 2;

  logic signed [COORD_WIDTH-1:0] pivot_r [3];
  logic [2:0]                    ang_we;
  logic                          trig_busy;
  logic signed [TW-1:0]          cos_w [3];
  logic signed [TW-1:0]          sin_w [3];

  logic                          dv_r, d_ready;
  logic signed [VW-1:0]          dx_r, dy_r, dz_r;

  logic                          ry_ready, ry_valid, rx_ready, rx_valid;
  logic                          rz_ready, rz_valid, o_ready;
  logic signed [VW-1:0]          ry_a, ry_b, ry_p;
  logic signed [VW-1:0]          rx_a, rx_b, rx_p;
  logic signed [VW-1:0]          rz_a, rz_b, rz_p;
  logic                          ov_r;

  // Register decode
  always_comb begin
    ang_we = '0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_Y: ang_we = 3'b001;
        CFG_ANGLE_X: ang_we = 3'b010;
        CFG_ANGLE_Z: ang_we = 3'b100;
        default:     ang_we = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) pivot_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIVOT_X: pivot_r[0] <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        CFG_PIVOT_Y: pivot_r[1] <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        CFG_PIVOT_Z: pivot_r[2] <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  prac_trig #(
    .ANGLE_WIDTH        (ANGLE_WIDTH),
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .ang_we    (ang_we),
    .ang_wdata (cfg_wdata[ANGLE_WIDTH-1:0]),
    .busy      (trig_busy),
    .cos_o     (cos_w),
    .sin_o     (sin_w)
  );

  // Subtract the pivot on entry
  assign d_ready        = !dv_r || ry_ready;
  assign in_point.ready = d_ready && !trig_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else if (d_ready) begin
      dv_r <= in_point.valid && !trig_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      dx_r <= VW'(in_point.point_x) - VW'(pivot_r[0]);
      dy_r <= VW'(in_point.point_y) - VW'(pivot_r[1]);
      dz_r <= VW'(in_point.point_z) - VW'(pivot_r[2]);
    end
  end

  // About Y: (z, x), y passes
  prac_rotate #(.VW(VW), .TW(TW), .F(TRIG_FRACTION_BITS)) u_rot_y (
    .clk (clk), .rst_n (rst_n),
    .in_valid (dv_r), .in_ready (ry_ready),
    .a_i (dz_r), .b_i (dx_r), .p_i (dy_r),
    .cos_i (cos_w[0]), .sin_i (sin_w[0]),
    .out_valid (ry_valid), .out_ready (rx_ready),
    .a_o (ry_a), .b_o (ry_b), .p_o (ry_p)
  );

  // About X: (y, z), x passes
  prac_rotate #(.VW(VW), .TW(TW), .F(TRIG_FRACTION_BITS)) u_rot_x (
    .clk (clk), .rst_n (rst_n),
    .in_valid (ry_valid), .in_ready (rx_ready),
    .a_i (ry_p), .b_i (ry_a), .p_i (ry_b),
    .cos_i (cos_w[1]), .sin_i (sin_w[1]),
    .out_valid (rx_valid), .out_ready (rz_ready),
    .a_o (rx_a), .b_o (rx_b), .p_o (rx_p)
  );

  // About Z: (x, y), z passes
  prac_rotate #(.VW(VW), .TW(TW), .F(TRIG_FRACTION_BITS)) u_rot_z (
    .clk (clk), .rst_n (rst_n),
    .in_valid (rx_valid), .in_ready (rz_ready),
    .a_i (rx_p), .b_i (rx_a), .p_i (rx_b),
    .cos_i (cos_w[2]), .sin_i (sin_w[2]),
    .out_valid (rz_valid), .out_ready (o_ready),
    .a_o (rz_a), .b_o (rz_b), .p_o (rz_p)
  );

  // Add the pivot back into the output register
  assign o_ready         = !ov_r || out_point.ready;
  assign out_point.valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (o_ready) begin
      ov_r <= rz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      out_point.rotated_x <= rz_a + VW'(pivot_r[0]);
      out_point.rotated_y <= rz_b + VW'(pivot_r[1]);
      out_point.rotated_z <= rz_p + VW'(pivot_r[2]);
    end
  end

  a_angle_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_ANGLE_Y || cfg_index == CFG_ANGLE_X ||
                cfg_index == CFG_ANGLE_Z)) |=> !in_point.ready)
    else $error("word taken while trig cache regenerates");

endmodule

// ===== verif/point_rotate_about_center_core_test.sv =====
module point_rotate_about_center_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prac_pkg::*;

  localparam int OUT_W = COORD_WIDTH + 3;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 3'd6;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } rotated_t;

  // Rotation predictor and store of expected rotated points
  class rotation_scoreboard;
    logic [ANGLE_WIDTH-1:0] angle[3];
    longint pivot[3];
    longint cos_q[3];
    longint sin_q[3];
    rotated_t pending_pts[$];
    int errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        angle[i] = '0;
        pivot[i] = 0;
        cos_q[i] = longint'(1) << TRIG_FRACTION_BITS;
        sin_q[i] = 0;
      end
      errors = 0;
    endfunction

    // Taylor sine of a first-quadrant remainder, Q30 then rounded
    function longint quarter_sine(longint unsigned r);
      longint unsigned quarter, x, t;
      longint s;
      quarter = longint'(1) << (ANGLE_WIDTH - 2);
      if (r == 0) return 0;
      if (r >= quarter) return longint'(1) << TRIG_FRACTION_BITS;
      x = (r * 64'd1686629713) >> (ANGLE_WIDTH - 2);
      s = longint'(x);
      t = x;
      for (int k = 1; k <= 8; k++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) s -= longint'(t);
        else s += longint'(t);
      end
      if (s < 0) s = 0;
      if (s > (longint'(1) << 30)) s = longint'(1) << 30;
      return longint'((longint'(s) + (longint'(1) << (29 - TRIG_FRACTION_BITS)))
                      >> (30 - TRIG_FRACTION_BITS));
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
      longint unsigned quarter, r;
      longint s, c;
      int a;
      quarter = longint'(1) << (ANGLE_WIDTH - 2);
      case (idx)
        CFG_ANGLE_Y, CFG_ANGLE_X, CFG_ANGLE_Z: begin
          a = idx;
          angle[a] = val[ANGLE_WIDTH-1:0];
          r = angle[a] & (quarter - 1);
          s = quarter_sine(r);
          c = quarter_sine(quarter - r);
          case (angle[a][ANGLE_WIDTH-1 -: 2])
            2'd0: begin sin_q[a] = s;  cos_q[a] = c;  end
            2'd1: begin sin_q[a] = c;  cos_q[a] = -s; end
            2'd2: begin sin_q[a] = -s; cos_q[a] = -c; end
            default: begin sin_q[a] = -c; cos_q[a] = s; end
          endcase
        end
        CFG_PIVOT_X, CFG_PIVOT_Y, CFG_PIVOT_Z:
          pivot[idx - CFG_PIVOT_X] = longint'($signed(val[COORD_WIDTH-1:0]));
        default: ;
      endcase
    endfunction

    function longint trunc_shift(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >>> TRIG_FRACTION_BITS;
      return (v < 0) ? -m : m;
    endfunction

    // Rotate (a, b) by axis n: a' = a*c - b*s, b' = a*s + b*c
    function void turn(inout longint a, inout longint b, input int n);
      longint na, nb;
      na = trunc_shift(a * cos_q[n] - b * sin_q[n]);
      nb = trunc_shift(a * sin_q[n] + b * cos_q[n]);
      a = na;
      b = nb;
    endfunction

    function void note_point(logic signed [COORD_WIDTH-1:0] px, py, pz);
      longint x, y, z;
      rotated_t e;
      x = longint'(px) - pivot[0];
      y = longint'(py) - pivot[1];
      z = longint'(pz) - pivot[2];
      if (angle[0] != 0) turn(z, x, 0);
      if (angle[1] != 0) turn(y, z, 1);
      if (angle[2] != 0) turn(x, y, 2);
      e.x = OUT_W'(x + pivot[0]);
      e.y = OUT_W'(y + pivot[1]);
      e.z = OUT_W'(z + pivot[2]);
      pending_pts.push_back(e);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] rx, ry, rz);
      rotated_t e;
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, rx, ry, rz);
        errors++;
        return;
      end
      e = pending_pts.pop_front();
      if (rx !== e.x) begin
        $display("%0t: rotated_x expected %0d actual %0d", $time, e.x, rx);
        errors++;
      end
      if (ry !== e.y) begin
        $display("%0t: rotated_y expected %0d actual %0d", $time, e.y, ry);
        errors++;
      end
      if (rz !== e.z) begin
        $display("%0t: rotated_z expected %0d actual %0d", $time, e.z, rz);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [15:0] cfg_wdata;
  bit quiet;
  int cycles;
  rotation_scoreboard sb;

  prac_in_if in_if ();
  prac_out_if out_if ();

  point_rotate_about_center_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_point  (in_if),
    .out_point (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_point(in_if.point_x, in_if.point_y, in_if.point_z);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.rotated_x, out_if.rotated_y, out_if.rotated_z);
    end
  end

  // Stall the result side in bursts
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 17);
        out_if.ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        out_if.ready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_point(logic signed [COORD_WIDTH-1:0] x, y, z);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 17);
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.point_x <= x;
    in_if.point_y <= y;
    in_if.point_z <= z;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Drain, then write one register; angle writes wait out regeneration
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
    in_if.valid <= 1'b0;
    while (sb.pending_pts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_ANGLE_Z) repeat (800) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ang[3];
    logic [15:0] piv[3];
    sb = new();
    quiet = 1'b0;
    cycles = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ANGLE_Y;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.point_x <= '0;
    in_if.point_y <= '0;
    in_if.point_z <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset angles pass points straight through
    send_point(16'sh7fff, 16'sh8000, 16'sh0000);
    send_point(16'sh8000, 16'sh7fff, -16'sd1);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin ang = '{16'd16384, 16'd0, 16'd0};
                 piv = '{16'h7fff, 16'h8000, 16'h0000}; end
        1: begin ang = '{16'd0, 16'd32768, 16'd0};
                 piv = '{16'h8000, 16'h7fff, 16'h8000}; end
        2: begin ang = '{16'd0, 16'd0, 16'd49152};
                 piv = '{16'h0000, 16'h0000, 16'h7fff}; end
        3: begin ang = '{16'd65535, 16'd1, 16'd16383};
                 piv = '{16'h8000, 16'h8000, 16'h8000}; end
        4: begin ang = '{16'd32767, 16'd49153, 16'd8192};
                 piv = '{16'h7fff, 16'h7fff, 16'h7fff}; end
        default: begin
          for (int i = 0; i < 3; i++) begin
            ang[i] = 16'($urandom);
            piv[i] = pick_coord();
          end
        end
      endcase
      write_reg(CFG_ANGLE_Y, ang[0]);
      write_reg(CFG_ANGLE_X, ang[1]);
      write_reg(CFG_ANGLE_Z, ang[2]);
      write_reg(CFG_PIVOT_X, piv[0]);
      write_reg(CFG_PIVOT_Y, piv[1]);
      write_reg(CFG_PIVOT_Z, piv[2]);
      if (p == 0) begin
        // Out-of-range index must not disturb any register
        write_reg(CFG_UNUSED, 16'hffff);
        send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_point(16'sh8000, 16'sh7fff, 16'sh8000);
        send_point(16'sh0000, 16'sh0000, 16'sh0000);
        send_point(-16'sd1, 16'sd1, -16'sd1);
      end
      if (p == 8) quiet = 1'b1;
      for (int k = 0; k < 66; k++)
        send_point(pick_coord(), pick_coord(), pick_coord());
    end
    in_if.valid <= 1'b0;

    while (sb.pending_pts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
